// ----- rtl/core/backcross_recombination_lod_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the backcross recombination block.
// Implication forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef BACKCROSS_RECOMBINATION_LOD_ASSERT_SVH
`define BACKCROSS_RECOMBINATION_LOD_ASSERT_SVH

`define BRL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define BRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/brl_pkg.sv -----
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants of the backcross recombination block.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [1:0] GENO_MISSING = 2'd0;
  localparam logic [1:0] GENO_ONE     = 2'd1;
  localparam logic [1:0] GENO_TWO     = 2'd2;
  localparam logic [1:0] GENO_BAD     = 2'd3;

  localparam logic [22:0] LOG10_2_Q24 = 23'd5050445;
  localparam logic [25:0] LOD_POS_MAX = 26'd1048575;
  localparam logic [25:0] LOD_NEG_MAG = 26'd1048576;

  typedef struct packed {
    logic [16:0]        rec_fraction;
    logic signed [20:0] lod_score;
    logic               no_data;
  } res_t;

endpackage

// ----- rtl/core/brl_calc.sv -----
// ----------------------------------------------------------------------------
// brl_calc
// Sequenced end-of-pair arithmetic: restoring divider for k/n and a shared
// multiplier for the squaring log2, the x*log2(x) terms and the LOD scaling.
// ----------------------------------------------------------------------------
module brl_calc #(
  parameter int unsigned CW = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [CW-1:0]  n_in,
  input  logic [CW-1:0]  k_in,
  input  logic           res_ready,
  output logic           busy,
  output logic           res_valid,
  output brl_pkg::res_t  res
);

  localparam int unsigned DW  = CW + 17;
  localparam int unsigned DCW = $clog2(DW);
  localparam int unsigned AW  = 57;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DIV  = 13'b0000000000010,
    S_NORM = 13'b0000000000100,
    S_SQ   = 13'b0000000001000,
    S_UPD  = 13'b0000000010000,
    S_MULF = 13'b0000000100000,
    S_ACCF = 13'b0000001000000,
    S_MULM = 13'b0000010000000,
    S_ACCM = 13'b0000100000000,
    S_FIN  = 13'b0001000000000,
    S_RND  = 13'b0010000000000,
    S_FMUL = 13'b0100000000000,
    S_FADD = 13'b1000000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 emit_r, emit_nxt;
  logic [CW-1:0]        n_r, n_nxt, k_r, k_nxt, x_r, x_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [DW-1:0]        dvd_r, dvd_nxt;
  logic [DCW-1:0]       dcnt_r, dcnt_nxt;
  logic [4:0]           m_r, m_nxt, icnt_r, icnt_nxt;
  logic [31:0]          y_r, y_nxt, frac_r, frac_nxt;
  logic [1:0]           term_r, term_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic [63:0]          prod_r, prod_nxt;
  logic [33:0]          m16_r, m16_nxt;
  logic                 neg_r, neg_nxt;
  brl_pkg::res_t        res_r, res_nxt;

  logic [31:0]    mul_a, mul_b;
  logic [CW:0]    div_r2;
  logic [4:0]     msb;
  logic [32:0]    sq_t;
  logic [AW-1:0]  term_val;
  logic [AW-1:0]  mag;
  logic [AW:0]    mag_rnd;
  logic [57:0]    lod_p;
  logic [25:0]    lod_q;
  logic [20:0]    lod_qn;

  always_comb begin
    msb = '0;
    for (int i = 0; i < CW; i++) begin
      if (x_r[i]) begin
        msb = 5'(i);
      end
    end
  end

  always_comb begin
    case (state_r)
      S_SQ: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      S_MULF: begin
        mul_a = 32'(x_r);
        mul_b = frac_r;
      end
      S_MULM: begin
        mul_a = 32'(x_r);
        mul_b = 32'(m_r);
      end
      S_FMUL: begin
        mul_a = m16_r[31:0];
        mul_b = 32'(brl_pkg::LOG10_2_Q24);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_r2   = {rem_r, dvd_r[DW-1]};
  assign sq_t     = prod_r[63:31];
  assign term_val = (state_r == S_ACCM) ? AW'({prod_r, 32'd0}) : AW'(prod_r);
  assign mag      = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign mag_rnd  = {1'b0, mag} + (AW+1)'(32768);
  assign lod_p    = 58'(prod_r) + {24'(m16_r[33:32] * brl_pkg::LOG10_2_Q24), 32'd0}
                    + 58'(64'h8000_0000);
  assign lod_q    = lod_p[57:32];
  assign lod_qn   = (lod_q > brl_pkg::LOD_NEG_MAG) ? brl_pkg::LOD_NEG_MAG[20:0] : lod_q[20:0];

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    dcnt_nxt  = dcnt_r;
    m_nxt     = m_r;
    icnt_nxt  = icnt_r;
    y_nxt     = y_r;
    frac_nxt  = frac_r;
    term_nxt  = term_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    m16_nxt   = m16_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (emit_r) begin
          if (res_ready) begin
            emit_nxt = 1'b0;
          end
        end else if (start) begin
          n_nxt = n_in;
          k_nxt = k_in;
          if (n_in == '0) begin
            res_nxt.rec_fraction = '0;
            res_nxt.lod_score    = '0;
            res_nxt.no_data      = 1'b1;
            emit_nxt             = 1'b1;
          end else begin
            res_nxt.no_data = 1'b0;
            dvd_nxt         = DW'({k_in, 16'd0}) + DW'(n_in >> 1);
            rem_nxt         = '0;
            dcnt_nxt        = DCW'(DW - 1);
            acc_nxt         = '0;
            term_nxt        = '0;
            x_nxt           = n_in - k_in;
            state_nxt       = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_r2 >= {1'b0, n_r}) begin
          rem_nxt = CW'(div_r2 - {1'b0, n_r});
          dvd_nxt = {dvd_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = div_r2[CW-1:0];
          dvd_nxt = {dvd_r[DW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        res_nxt.rec_fraction = dvd_r[16:0];
        m_nxt     = msb;
        y_nxt     = 32'(x_r) << (5'd31 - msb);
        frac_nxt  = '0;
        icnt_nxt  = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        frac_nxt  = {frac_r[30:0], sq_t[32]};
        y_nxt     = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        icnt_nxt  = icnt_r + 1'b1;
        state_nxt = (icnt_r == 5'd31) ? S_MULF : S_SQ;
      end
      S_MULF: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_ACCF;
      end
      S_ACCF: begin
        acc_nxt   = (term_r == 2'd2) ? acc_r - $signed(term_val) : acc_r + $signed(term_val);
        state_nxt = S_MULM;
      end
      S_MULM: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_ACCM;
      end
      S_ACCM: begin
        acc_nxt = (term_r == 2'd2) ? acc_r - $signed(term_val) : acc_r + $signed(term_val);
        if (term_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          term_nxt  = term_r + 1'b1;
          x_nxt     = (term_r == 2'd0) ? k_r : n_r;
          state_nxt = S_NORM;
        end
      end
      S_FIN: begin
        acc_nxt   = acc_r + $signed(AW'({n_r, 32'd0}));
        state_nxt = S_RND;
      end
      S_RND: begin
        neg_nxt   = acc_r[AW-1];
        m16_nxt   = mag_rnd[49:16];
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_FADD;
      end
      S_FADD: begin
        if (neg_r) begin
          res_nxt.lod_score = $signed(21'(~lod_qn + 21'd1));
        end else if (lod_q > brl_pkg::LOD_POS_MAX) begin
          res_nxt.lod_score = $signed(brl_pkg::LOD_POS_MAX[20:0]);
        end else begin
          res_nxt.lod_score = $signed(lod_q[20:0]);
        end
        emit_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dcnt_r <= dcnt_nxt;
    m_r    <= m_nxt;
    icnt_r <= icnt_nxt;
    y_r    <= y_nxt;
    frac_r <= frac_nxt;
    term_r <= term_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    m16_r  <= m16_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE) || emit_r;
  assign res_valid = emit_r;
  assign res       = res_r;

endmodule

// ----- rtl/core/backcross_recombination_lod.sv -----
// A non-last item is added to the registered counters; one item per cycle while
// in_tready is high. A last item starts the end-of-pair unit: a radix-2 divider,
// three squaring log2 runs on one shared multiplier and the LOD scaling steps
// (fin, round, multiply, add), whose result then goes to the output register.
// Input is not taken while that unit runs. Reset (rst_n low, synchronous)
// clears the counters, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// backcross_recombination_lod
// Counts recombinant and missing genotype pairs and reports r and LOD per pair.
// ----------------------------------------------------------------------------
module backcross_recombination_lod #(
  parameter int unsigned MAX_INDIVIDUALS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [brl_pkg::IN_TDATA_W-1:0]      in_tdata,  // geno_a[1:0], geno_b[3:2]
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [brl_pkg::OUT_TDATA_W-1:0]     out_tdata, // rec_fraction[16:0], lod_score[37:17]
  output logic                                out_tuser  // no_data
);

  localparam int unsigned CW = $clog2(MAX_INDIVIDUALS + 1);

  logic [CW-1:0] total_r, total_nxt, rec_r, rec_nxt, miss_r, miss_nxt;
  logic [1:0]    geno_a, geno_b;
  logic          acc_in, is_rec, is_miss, res_ready, calc_busy, calc_valid;
  logic          out_valid_r, out_valid_nxt;
  brl_pkg::res_t calc_res, out_r, out_nxt;

  assign geno_a  = in_tdata[1:0];
  assign geno_b  = in_tdata[3:2];
  assign acc_in  = in_tvalid && in_tready;
  assign is_rec  = (geno_a == brl_pkg::GENO_ONE && geno_b == brl_pkg::GENO_TWO) ||
                   (geno_a == brl_pkg::GENO_TWO && geno_b == brl_pkg::GENO_ONE);
  assign is_miss = (geno_a == brl_pkg::GENO_MISSING) || (geno_b == brl_pkg::GENO_MISSING) ||
                   (geno_a == brl_pkg::GENO_BAD) || (geno_b == brl_pkg::GENO_BAD);

  always_comb begin
    total_nxt = total_r;
    rec_nxt   = rec_r;
    miss_nxt  = miss_r;
    if (acc_in && (total_r < CW'(MAX_INDIVIDUALS))) begin
      total_nxt = total_r + 1'b1;
      if (is_rec) begin
        rec_nxt = rec_r + 1'b1;
      end else if (is_miss) begin
        miss_nxt = miss_r + 1'b1;
      end
    end
  end

  assign in_tready = !calc_busy;
  assign res_ready = !out_valid_r || out_tready;

  brl_calc #(
    .CW (CW)
  ) u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (acc_in && in_tlast),
    .n_in      (total_nxt - miss_nxt),
    .k_in      (rec_nxt),
    .res_ready (res_ready),
    .busy      (calc_busy),
    .res_valid (calc_valid),
    .res       (calc_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (calc_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = calc_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      rec_r       <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc_in && in_tlast) begin
        total_r <= '0;
        rec_r   <= '0;
        miss_r  <= '0;
      end else begin
        total_r <= total_nxt;
        rec_r   <= rec_nxt;
        miss_r  <= miss_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.lod_score, out_r.rec_fraction};
  assign out_tuser  = out_r.no_data;

endmodule

// ----- rtl/core/brl_checker.sv -----
// ----------------------------------------------------------------------------
// brl_checker
// Port-level checks of the backcross recombination block, bound to the top.
// ----------------------------------------------------------------------------
`include "backcross_recombination_lod_assert.svh"

module brl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [brl_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [brl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  `BRL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BRL_ASSERT_SAME(a_no_data_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata[37:0] == 38'd0)
  `BRL_ASSERT_SAME(a_rec_range, clk, rst_n, out_tvalid, !(out_tdata[16] && (out_tdata[15:0] != 16'd0)))
  `BRL_ASSERT_NEXT(a_last_busy, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready)

endmodule

bind backcross_recombination_lod brl_checker u_brl_checker (.*);
